@@ rtl/script_variable_store_assert.svh @@
// ----------------------------------------------------------------------------
// Script variable store assertion macros
// Shared property forms for the variable store modules. They sample on clk
// and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_VARIABLE_STORE_ASSERT_SVH
`define SCRIPT_VARIABLE_STORE_ASSERT_SVH

// Same-cycle implication.
`define SVS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svs same-cycle check failed");

// Next-cycle implication.
`define SVS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svs next-cycle check failed");

`endif

@@ rtl/svs_pkg.sv @@
// ----------------------------------------------------------------------------
// Script variable store package
// Sizes, identifier constants, the queued word type and the identifier decoder.
// ----------------------------------------------------------------------------
package svs_pkg;

	localparam int NUM_GLOBALS = 1024;
	localparam int NUM_BITS    = 4096;
	localparam int NUM_LOCALS  = 32;
	localparam int NUM_SLOTS   = 32;

	localparam int LOC_DEPTH = NUM_SLOTS * NUM_LOCALS;

	localparam int GLB_AW = (NUM_GLOBALS > 1) ? $clog2(NUM_GLOBALS) : 1;
	localparam int BIT_AW = $clog2(NUM_BITS);
	localparam int LOC_AW = (LOC_DEPTH > 1) ? $clog2(LOC_DEPTH) : 1;
	localparam int AW_GB  = (GLB_AW > BIT_AW) ? GLB_AW : BIT_AW;
	localparam int AW     = (AW_GB > LOC_AW) ? AW_GB : LOC_AW;

	localparam int CLR_GB = (NUM_GLOBALS > NUM_BITS) ? NUM_GLOBALS : NUM_BITS;
	localparam int CLR_N  = (CLR_GB > LOC_DEPTH) ? CLR_GB : LOC_DEPTH;
	localparam int CLR_W  = $clog2(CLR_N);

	localparam int ID_W   = 16;
	localparam int SLOT_W = 5;
	localparam int VAL_W  = 32;

	localparam logic [ID_W-1:0] ID_INDEXED     = 16'h2000;
	localparam logic [ID_W-1:0] ID_POOL_NIBBLE = 16'hF000;
	localparam logic [ID_W-1:0] ID_BIT_POOL    = 16'h8000;
	localparam logic [ID_W-1:0] ID_BIT_MASK    = 16'h7FFF;
	localparam logic [ID_W-1:0] ID_LOCAL_POOL  = 16'h4000;
	localparam logic [ID_W-1:0] ID_LOCAL_MASK  = 16'h0FFF;
	localparam logic [ID_W-1:0] OFFSET_MASK    = 16'h0FFF;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] POOL_NONE = 2'd0;
	localparam logic [1:0] POOL_GLB  = 2'd1;
	localparam logic [1:0] POOL_BIT  = 2'd2;
	localparam logic [1:0] POOL_LOC  = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              op;
		logic              need_ind;
		logic              clr13;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   ofs_id;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  wv;
	} svs_item_t;

	typedef struct packed {
		logic [1:0]    pool;
		logic [AW-1:0] addr;
	} svs_loc_t;

	function automatic svs_loc_t svs_decode(input logic [ID_W-1:0] id,
		input logic [SLOT_W-1:0] slot);
		svs_loc_t r;
		logic [ID_W-1:0] i;
		r.pool = POOL_NONE;
		r.addr = '0;
		i = '0;
		if ((id & ID_POOL_NIBBLE) == '0) begin
			if (32'(id) < NUM_GLOBALS) begin
				r.pool = POOL_GLB;
				r.addr = AW'(id);
			end
		end else if ((id & ID_BIT_POOL) != '0) begin
			i = id & ID_BIT_MASK;
			if (32'(i) < NUM_BITS) begin
				r.pool = POOL_BIT;
				r.addr = AW'(i);
			end
		end else if ((id & ID_LOCAL_POOL) != '0) begin
			i = id & ID_LOCAL_MASK;
			if (32'(i) < NUM_LOCALS && 32'(slot) < NUM_SLOTS) begin
				r.pool = POOL_LOC;
				r.addr = AW'(32'(slot) * NUM_LOCALS + 32'(i));
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/svs_front.sv @@
// ----------------------------------------------------------------------------
// Script variable store front end
// Accepts access words, folds in a direct offset and marks accesses that need
// an offset variable read, then hands them to the queue.
// ----------------------------------------------------------------------------
module svs_front import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [ID_W-1:0]          var_id,
	input  logic [ID_W-1:0]          index_word,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [VAL_W-1:0]  write_value,
	output logic                     push,
	output svs_item_t                item,
	input  logic                     q_full
);

	logic            valid_s1;
	svs_item_t       item_s1;
	svs_item_t       cls;
	logic            indexed;
	logic [ID_W-1:0] id_clr;
	logic [ID_W-1:0] dofs;

	always_comb begin
		indexed      = var_id[13];
		id_clr       = var_id & ~ID_INDEXED;
		dofs         = index_word & OFFSET_MASK;
		cls.op       = opcode;
		cls.need_ind = indexed && index_word[13];
		cls.clr13    = (opcode == OP_READ);
		cls.ofs_id   = index_word & ~ID_INDEXED;
		cls.slot     = slot;
		cls.wv       = $unsigned(write_value);
		if (!indexed) begin
			cls.id = var_id;
		end else if (cls.need_ind) begin
			cls.id = (opcode == OP_WRITE) ? id_clr : var_id;
		end else if (opcode == OP_READ) begin
			cls.id = (var_id + dofs) & ~ID_INDEXED;
		end else begin
			cls.id = id_clr + dofs;
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= cls;
		end
	end

endmodule

@@ rtl/svs_queue.sv @@
// ----------------------------------------------------------------------------
// Script variable store queue
// Short first-in first-out buffer of classified words between the front end
// and the executing back end.
// ----------------------------------------------------------------------------
`include "script_variable_store_assert.svh"

module svs_queue import svs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  svs_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      nonempty,
	output svs_item_t head
);

	svs_item_t           buf_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_item;
		end
	end

	`SVS_ASSERT_IMP(a_q_no_overflow, full, !(push && !pop))
	`SVS_ASSERT_IMP(a_q_no_underflow, !nonempty, !pop)

endmodule

@@ rtl/svs_back.sv @@
// ----------------------------------------------------------------------------
// Script variable store back end
// Holds the global, bit and local stores, resolves offsets through a variable
// read, performs the access and registers the result word.
// ----------------------------------------------------------------------------
`include "script_variable_store_assert.svh"

module svs_back import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  svs_item_t                head,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VAL_W-1:0]  read_value,
	output logic [ID_W-1:0]          resolved_id,
	output logic                     bad_access
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_OFS   = 2'd2;
	localparam logic [1:0] ST_RES   = 2'd3;

	logic [VAL_W-1:0] glb_mem [NUM_GLOBALS];
	logic             bit_mem [NUM_BITS];
	logic [VAL_W-1:0] loc_mem [LOC_DEPTH];

	logic [1:0]       state_q;
	logic [CLR_W-1:0] clr_q;
	svs_item_t        cur_q;
	logic [VAL_W-1:0] glb_rd_q;
	logic             bit_rd_q;
	logic [VAL_W-1:0] loc_rd_q;
	logic [1:0]       rd_pool_q;
	logic [ID_W-1:0]  res_id_q;
	logic             bad_q;
	logic             is_rd_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] rv_q;
	logic [ID_W-1:0]  rid_q;
	logic             bad_out_q;

	svs_item_t        acc_item;
	svs_loc_t         ofs_loc;
	svs_loc_t         acc_loc;
	svs_loc_t         mem_loc;
	logic [VAL_W-1:0] rd_sel;
	logic [ID_W-1:0]  ofs_sum;
	logic [ID_W-1:0]  ofs_res;
	logic [ID_W-1:0]  acc_id;
	logic             access;
	logic             ofs_rd;
	logic             rd_en;
	logic             we;
	logic             out_load;
	logic             clr_glb;
	logic             clr_bit;
	logic             clr_loc;

	always_comb begin
		case (rd_pool_q)
			POOL_GLB: rd_sel = glb_rd_q;
			POOL_BIT: rd_sel = {{(VAL_W-1){1'b0}}, bit_rd_q};
			POOL_LOC: rd_sel = loc_rd_q;
			default:  rd_sel = '0;
		endcase
	end

	always_comb begin
		pop      = (state_q == ST_IDLE) && q_valid;
		ofs_rd   = pop && head.need_ind;
		access   = (pop && !head.need_ind) || (state_q == ST_OFS);
		acc_item = (state_q == ST_IDLE) ? head : cur_q;
		ofs_sum  = cur_q.id + rd_sel[ID_W-1:0];
		ofs_res  = cur_q.clr13 ? (ofs_sum & ~ID_INDEXED) : ofs_sum;
		acc_id   = (state_q == ST_IDLE) ? head.id : ofs_res;
		ofs_loc  = svs_decode(head.ofs_id, head.slot);
		acc_loc  = svs_decode(acc_id, acc_item.slot);
		mem_loc  = ofs_rd ? ofs_loc : acc_loc;
		rd_en    = ofs_rd || (access && acc_item.op == OP_READ);
		we       = access && acc_item.op == OP_WRITE;
		out_load = !out_valid_q || !out_stall;
		clr_glb  = (state_q == ST_CLEAR) && (32'(clr_q) < NUM_GLOBALS);
		clr_bit  = (state_q == ST_CLEAR) && (32'(clr_q) < NUM_BITS);
		clr_loc  = (state_q == ST_CLEAR) && (32'(clr_q) < LOC_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (clr_glb) begin
			glb_mem[clr_q[GLB_AW-1:0]] <= '0;
		end else if (we && mem_loc.pool == POOL_GLB) begin
			glb_mem[mem_loc.addr[GLB_AW-1:0]] <= acc_item.wv;
		end
		if (rd_en) begin
			glb_rd_q <= glb_mem[mem_loc.addr[GLB_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_bit) begin
			bit_mem[clr_q[BIT_AW-1:0]] <= 1'b0;
		end else if (we && mem_loc.pool == POOL_BIT) begin
			bit_mem[mem_loc.addr[BIT_AW-1:0]] <= |acc_item.wv;
		end
		if (rd_en) begin
			bit_rd_q <= bit_mem[mem_loc.addr[BIT_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_loc) begin
			loc_mem[clr_q[LOC_AW-1:0]] <= '0;
		end else if (we && mem_loc.pool == POOL_LOC) begin
			loc_mem[mem_loc.addr[LOC_AW-1:0]] <= acc_item.wv;
		end
		if (rd_en) begin
			loc_rd_q <= loc_mem[mem_loc.addr[LOC_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_pool_q   <= POOL_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_pool_q <= mem_loc.pool;
			end
			if (out_load) begin
				out_valid_q <= (state_q == ST_RES);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (ofs_rd) begin
						state_q <= ST_OFS;
					end else if (pop) begin
						state_q <= ST_RES;
					end
				end
				ST_OFS: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (access) begin
			res_id_q <= acc_id;
			bad_q    <= (acc_loc.pool == POOL_NONE);
			is_rd_q  <= (acc_item.op == OP_READ);
		end
		if (out_load && state_q == ST_RES) begin
			rv_q      <= is_rd_q ? rd_sel : '0;
			rid_q     <= res_id_q;
			bad_out_q <= bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = $signed(rv_q);
	assign resolved_id = rid_q;
	assign bad_access  = bad_out_q;

	`SVS_ASSERT_IMP(a_bad_reads_zero, out_valid_q && bad_out_q, rv_q == '0)
	`SVS_ASSERT_NXT(a_ofs_then_result, state_q == ST_OFS, state_q == ST_RES)
	`SVS_ASSERT_NXT(a_res_holds, state_q == ST_RES && !out_load,
		state_q == ST_RES && $stable(res_id_q))

endmodule

@@ rtl/script_variable_store.sv @@
// ----------------------------------------------------------------------------
// Script variable store
// Variable file of a script machine: global words, bit flags and per-slot
// local words, addressed by 16-bit identifiers with an optional offset word.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid / in_stall  opcode var_id index_word slot write_value
//   out       out_valid/out_stall  read_value resolved_id bad_access
//
// A word passes the front register and queue, then the back end's access and
// result steps; an offset held in another variable adds a store read first.
// The single read port of each store sets the pace; one word executes at a time.
// After reset the back end clears all stores; words queue meanwhile.
// A stalled result holds the back end; the front and queue fill with words.
// ----------------------------------------------------------------------------
module script_variable_store import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [ID_W-1:0]          var_id,
	input  logic [ID_W-1:0]          index_word,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [VAL_W-1:0]  write_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VAL_W-1:0]  read_value,
	output logic [ID_W-1:0]          resolved_id,
	output logic                     bad_access
);

	logic      push;
	svs_item_t push_item;
	logic      q_full;
	logic      q_valid;
	logic      pop;
	svs_item_t head;

	svs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.var_id      (var_id),
		.index_word  (index_word),
		.slot        (slot),
		.write_value (write_value),
		.push        (push),
		.item        (push_item),
		.q_full      (q_full)
	);

	svs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_valid),
		.head      (head)
	);

	svs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.resolved_id (resolved_id),
		.bad_access  (bad_access)
	);

endmodule
